/* rtl/core/mcet_pkg.sv */
// shared types, codes and constants of the mouse cursor event tracker
`timescale 1ns / 1ps
`default_nettype none

package mcet_pkg;

    // coordinate and field widths
    localparam int COORD_BITS = 15;
    localparam int DELTA_BITS = 16;
    localparam int FLAG_BITS  = 11;
    localparam int DATA_BITS  = 16;
    localparam int KIND_BITS  = 4;
    localparam int MASK_BITS  = 5;
    localparam int SUM_BITS   = ((COORD_BITS > DELTA_BITS) ? COORD_BITS : DELTA_BITS) + 2;

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_ENABLE   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT     = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RIGHT    = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_TOP      = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_BOTTOM   = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWAP_BUTTONS  = 4'd7;

    // register values after reset
    localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = COORD_BITS'(1024);
    localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = COORD_BITS'(768);
    localparam logic [COORD_BITS-1:0] RST_CLIP_LEFT     = '0;
    localparam logic [COORD_BITS-1:0] RST_CLIP_RIGHT    = '1;
    localparam logic [COORD_BITS-1:0] RST_CLIP_TOP      = '0;
    localparam logic [COORD_BITS-1:0] RST_CLIP_BOTTOM   = '1;

    // event flag bit positions
    localparam int F_MOVE     = 0;
    localparam int F_LDOWN    = 1;
    localparam int F_LUP      = 2;
    localparam int F_RDOWN    = 3;
    localparam int F_RUP      = 4;
    localparam int F_MDOWN    = 5;
    localparam int F_MUP      = 6;
    localparam int F_XDOWN    = 7;
    localparam int F_XUP      = 8;
    localparam int F_WHEEL    = 9;
    localparam int F_ABSOLUTE = 10;

    // held mask bit positions
    localparam int B_LEFT   = 0;
    localparam int B_RIGHT  = 1;
    localparam int B_MIDDLE = 2;
    localparam int B_X1     = 3;
    localparam int B_X2     = 4;

    typedef logic [KIND_BITS-1:0] t_kind;
    typedef logic [MASK_BITS-1:0] t_mask;

    // message kinds
    localparam t_kind K_MOVE   = 4'd0;
    localparam t_kind K_LDOWN  = 4'd1;
    localparam t_kind K_LUP    = 4'd2;
    localparam t_kind K_RDOWN  = 4'd3;
    localparam t_kind K_RUP    = 4'd4;
    localparam t_kind K_MDOWN  = 4'd5;
    localparam t_kind K_MUP    = 4'd6;
    localparam t_kind K_XDOWN  = 4'd7;
    localparam t_kind K_XUP    = 4'd8;
    localparam t_kind K_WHEEL  = 4'd9;
    localparam t_kind K_REJECT = 4'd10;

    // message slots of one event, in emission order
    localparam int SLOT_COUNT = 7;
    localparam int SLOT_BITS  = 3;
    localparam logic [SLOT_BITS-1:0] SLOT_MOVE  = 3'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_LEFT  = 3'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_MID   = 3'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_RIGHT = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_X1    = 3'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_X2    = 3'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_TAIL  = 3'd6;

    // X button numbers carried in detail
    localparam logic signed [DATA_BITS-1:0] DETAIL_X1 = 16'sd1;
    localparam logic signed [DATA_BITS-1:0] DETAIL_X2 = 16'sd2;

    // queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] screen_width;
        logic [COORD_BITS-1:0] screen_height;
        logic                  clip_enable;
        logic [COORD_BITS-1:0] clip_left;
        logic [COORD_BITS-1:0] clip_right;
        logic [COORD_BITS-1:0] clip_top;
        logic [COORD_BITS-1:0] clip_bottom;
        logic                  swap_buttons;
    } t_cfg;

    // one classified event: which messages go out and what they carry
    typedef struct packed {
        logic [SLOT_COUNT-1:0]        slot_en;
        logic [COORD_BITS-1:0]        pos_x;
        logic [COORD_BITS-1:0]        pos_y;
        t_kind                        kind_l;
        t_kind                        kind_m;
        t_kind                        kind_r;
        t_kind                        kind_x;
        t_kind                        kind_tail;
        t_mask                        held_snap;
        t_mask                        held_lmr;
        t_mask                        held_x1;
        t_mask                        held_x2;
        logic signed [DATA_BITS-1:0]  tail_detail;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/core/mcet_front.sv */
// front end: takes mouse events, tracks cursor and buttons, builds message lists
`timescale 1ns / 1ps
`default_nettype none

module mcet_front (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_in_valid,
    output logic                                      o_in_stall,
    input  wire signed [mcet_pkg::DELTA_BITS-1:0]     i_delta_x,
    input  wire signed [mcet_pkg::DELTA_BITS-1:0]     i_delta_y,
    input  wire        [mcet_pkg::FLAG_BITS-1:0]      i_event_flags,
    input  wire signed [mcet_pkg::DATA_BITS-1:0]      i_mouse_data,
    input  mcet_pkg::t_cfg                            i_cfg,
    input  wire                                       i_queue_full,
    output logic                                      o_push,
    output mcet_pkg::t_entry                          o_entry
);
    import mcet_pkg::*;

    // clamp one axis to the screen, then to the clip bounds
    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SUM_BITS-1:0] p_in,
        input logic [COORD_BITS-1:0]      size,
        input logic                       clip_on,
        input logic [COORD_BITS-1:0]      lo,
        input logic [COORD_BITS-1:0]      hi
    );
        logic signed [SUM_BITS-1:0] p;
        logic signed [SUM_BITS-1:0] s_size;
        logic signed [SUM_BITS-1:0] s_lo;
        logic signed [SUM_BITS-1:0] s_hi;
        logic signed [SUM_BITS-1:0] s_max;
        begin
            p      = p_in;
            s_size = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, size});
            s_lo   = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, lo});
            s_hi   = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, hi});
            s_max  = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
            if (p >= s_size) begin
                p = s_size - SUM_BITS'(1);
            end
            if (p < 0) begin
                p = '0;
            end
            if (clip_on) begin
                if (p >= s_hi) begin
                    p = s_hi;
                end
                if (p < s_lo) begin
                    p = s_lo;
                end
            end
            if (p > s_max) begin
                p = s_max;
            end
            clamp_axis = p[COORD_BITS-1:0];
        end
    endfunction

    logic [COORD_BITS-1:0]       r_cursor_x;
    logic [COORD_BITS-1:0]       r_cursor_y;
    t_mask                       r_held;
    logic [COORD_BITS-1:0]       n_cursor_x;
    logic [COORD_BITS-1:0]       n_cursor_y;
    t_mask                       n_held;

    logic                        accept;
    logic                        swap;
    logic signed [SUM_BITS-1:0]  ext_dx;
    logic signed [SUM_BITS-1:0]  ext_dy;
    logic signed [SUM_BITS-1:0]  raw_x;
    logic signed [SUM_BITS-1:0]  raw_y;
    logic [COORD_BITS-1:0]       new_x;
    logic [COORD_BITS-1:0]       new_y;
    logic                        moved;
    logic [1:0]                  lr_bit;
    t_mask                       held_lmr;
    t_mask                       held_x1;
    t_mask                       held_x2;
    logic                        x_any;
    logic                        wheel;
    logic                        reject;
    logic                        x1_en;
    logic                        x2_en;
    logic                        x_down;
    t_entry                      entry;

    assign accept     = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;
    assign swap       = i_cfg.swap_buttons;

    // new position after the move
    always_comb begin
        ext_dx = $signed({{(SUM_BITS-DELTA_BITS){i_delta_x[DELTA_BITS-1]}}, i_delta_x});
        ext_dy = $signed({{(SUM_BITS-DELTA_BITS){i_delta_y[DELTA_BITS-1]}}, i_delta_y});
        if (i_event_flags[F_ABSOLUTE]) begin
            raw_x = ext_dx;
            raw_y = ext_dy;
        end else begin
            raw_x = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, r_cursor_x}) + ext_dx;
            raw_y = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, r_cursor_y}) + ext_dy;
        end
        new_x = clamp_axis(raw_x, i_cfg.screen_width, i_cfg.clip_enable,
                           i_cfg.clip_left, i_cfg.clip_right);
        new_y = clamp_axis(raw_y, i_cfg.screen_height, i_cfg.clip_enable,
                           i_cfg.clip_top, i_cfg.clip_bottom);
        moved = i_event_flags[F_MOVE] && ((new_x != r_cursor_x) || (new_y != r_cursor_y));
    end

    // classify buttons and wheel, build the message slots
    always_comb begin
        entry  = '0;
        lr_bit = swap ? 2'b10 : 2'b01;

        entry.slot_en[SLOT_MOVE] = moved;
        entry.pos_x     = moved ? new_x : r_cursor_x;
        entry.pos_y     = moved ? new_y : r_cursor_y;
        entry.held_snap = r_held;

        held_lmr = r_held;

        // left slot
        if (i_event_flags[F_LDOWN]) begin
            entry.slot_en[SLOT_LEFT] = 1'b1;
            entry.kind_l = swap ? K_RDOWN : K_LDOWN;
            held_lmr[B_RIGHT:B_LEFT] = held_lmr[B_RIGHT:B_LEFT] | lr_bit;
        end else if (i_event_flags[F_LUP]) begin
            entry.slot_en[SLOT_LEFT] = 1'b1;
            entry.kind_l = swap ? K_RUP : K_LUP;
            held_lmr[B_RIGHT:B_LEFT] = held_lmr[B_RIGHT:B_LEFT] & ~lr_bit;
        end

        // middle slot
        if (i_event_flags[F_MDOWN]) begin
            entry.slot_en[SLOT_MID] = 1'b1;
            entry.kind_m = K_MDOWN;
            held_lmr[B_MIDDLE] = 1'b1;
        end else if (i_event_flags[F_MUP]) begin
            entry.slot_en[SLOT_MID] = 1'b1;
            entry.kind_m = K_MUP;
            held_lmr[B_MIDDLE] = 1'b0;
        end

        // right slot
        if (i_event_flags[F_RDOWN]) begin
            entry.slot_en[SLOT_RIGHT] = 1'b1;
            entry.kind_r = swap ? K_LDOWN : K_RDOWN;
            held_lmr[B_RIGHT:B_LEFT] = held_lmr[B_RIGHT:B_LEFT] | ~lr_bit;
        end else if (i_event_flags[F_RUP]) begin
            entry.slot_en[SLOT_RIGHT] = 1'b1;
            entry.kind_r = swap ? K_LUP : K_RUP;
            held_lmr[B_RIGHT:B_LEFT] = held_lmr[B_RIGHT:B_LEFT] & lr_bit;
        end

        // X buttons, wheel, and the rejected combination of both
        x_any  = i_event_flags[F_XDOWN] || i_event_flags[F_XUP];
        wheel  = i_event_flags[F_WHEEL];
        reject = x_any && wheel;
        x_down = i_event_flags[F_XDOWN];
        x1_en  = x_any && !wheel && i_mouse_data[0];
        x2_en  = x_any && !wheel && i_mouse_data[1];

        held_x1 = held_lmr;
        if (x1_en) begin
            held_x1[B_X1] = x_down;
        end
        held_x2 = held_x1;
        if (x2_en) begin
            held_x2[B_X2] = x_down;
        end

        entry.slot_en[SLOT_X1]   = x1_en;
        entry.slot_en[SLOT_X2]   = x2_en;
        entry.slot_en[SLOT_TAIL] = wheel;
        entry.kind_x      = x_down ? K_XDOWN : K_XUP;
        entry.kind_tail   = reject ? K_REJECT : K_WHEEL;
        entry.tail_detail = reject ? '0 : i_mouse_data;
        entry.held_lmr    = held_lmr;
        entry.held_x1     = held_x1;
        entry.held_x2     = held_x2;
    end

    // next tracked state
    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_held     = r_held;
        if (accept) begin
            n_cursor_x = entry.pos_x;
            n_cursor_y = entry.pos_y;
            n_held     = held_x2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_held     <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_held     <= n_held;
        end
    end

    // events with at least one message go to the queue
    assign o_push  = accept && (entry.slot_en != '0);
    assign o_entry = entry;

endmodule

`default_nettype wire

/* rtl/core/mcet_queue.sv */
// small request queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module mcet_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mcet_pkg::t_entry  i_entry,
    output logic              o_full,
    output logic              o_valid,
    input  wire               i_pop,
    output mcet_pkg::t_entry  o_head
);
    import mcet_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr;
    logic [QCNT_BITS-1:0]   r_count;
    logic [QCNT_BITS-1:0]   n_count;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mcet_back.sv */
// back end: walks the message slots of the head request, one message a cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module mcet_back (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_q_valid,
    input  mcet_pkg::t_entry                        i_q_head,
    output logic                                    o_q_pop,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic [mcet_pkg::KIND_BITS-1:0]          o_message_kind,
    output logic [mcet_pkg::MASK_BITS-1:0]          o_held_buttons,
    output logic signed [mcet_pkg::DATA_BITS-1:0]  o_detail,
    output logic [mcet_pkg::COORD_BITS-1:0]         o_pos_x,
    output logic [mcet_pkg::COORD_BITS-1:0]         o_pos_y,
    output logic                                    o_last
);
    import mcet_pkg::*;

    logic [SLOT_COUNT-1:0]        r_sent;
    logic [SLOT_COUNT-1:0]        n_sent;
    logic                         r_out_valid;
    t_kind                        r_kind;
    t_mask                        r_held;
    logic signed [DATA_BITS-1:0]  r_detail;
    logic [COORD_BITS-1:0]        r_pos_x;
    logic [COORD_BITS-1:0]        r_pos_y;
    logic                         r_last;

    logic                         out_free;
    logic                         emit;
    logic [SLOT_COUNT-1:0]        pending;
    logic [SLOT_COUNT-1:0]        sel;
    logic [SLOT_BITS-1:0]         slot;
    logic                         found;
    logic                         last;
    t_kind                        kind;
    t_mask                        held;
    logic signed [DATA_BITS-1:0]  detail;

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = i_q_valid && out_free;

    // lowest pending slot of the head request
    always_comb begin
        pending = i_q_head.slot_en & ~r_sent;
        sel     = '0;
        slot    = SLOT_MOVE;
        found   = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (pending[i] && !found) begin
                found  = 1'b1;
                sel[i] = 1'b1;
                slot   = SLOT_BITS'(i);
            end
        end
        last = ((pending & ~sel) == '0);
    end

    // fields of the selected message
    always_comb begin
        case (slot)
            SLOT_MOVE: begin
                kind   = K_MOVE;
                held   = i_q_head.held_snap;
                detail = '0;
            end
            SLOT_LEFT: begin
                kind   = i_q_head.kind_l;
                held   = i_q_head.held_snap;
                detail = '0;
            end
            SLOT_MID: begin
                kind   = i_q_head.kind_m;
                held   = i_q_head.held_snap;
                detail = '0;
            end
            SLOT_RIGHT: begin
                kind   = i_q_head.kind_r;
                held   = i_q_head.held_snap;
                detail = '0;
            end
            SLOT_X1: begin
                kind   = i_q_head.kind_x;
                held   = i_q_head.held_lmr;
                detail = DETAIL_X1;
            end
            SLOT_X2: begin
                kind   = i_q_head.kind_x;
                held   = i_q_head.held_x1;
                detail = DETAIL_X2;
            end
            SLOT_TAIL: begin
                kind   = i_q_head.kind_tail;
                held   = i_q_head.held_x2;
                detail = i_q_head.tail_detail;
            end
            default: begin
                kind   = K_MOVE;
                held   = i_q_head.held_snap;
                detail = '0;
            end
        endcase
    end

    // slot progress of the head request
    always_comb begin
        n_sent = r_sent;
        if (emit) begin
            n_sent = last ? '0 : (r_sent | sel);
        end
    end

    assign o_q_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sent <= n_sent;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= kind;
            r_held   <= held;
            r_detail <= detail;
            r_pos_x  <= i_q_head.pos_x;
            r_pos_y  <= i_q_head.pos_y;
            r_last   <= last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_message_kind = r_kind;
    assign o_held_buttons = r_held;
    assign o_detail       = r_detail;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_last         = r_last;

endmodule

`default_nettype wire

/* rtl/core/mouse_cursor_event_tracker_core.sv */
// top level of the mouse cursor event tracker: configuration registers and the two ends
`timescale 1ns / 1ps
`default_nettype none

// Mouse cursor event tracker. Each accepted mouse event moves the cursor (relative or
// absolute, clamped to the screen and optionally to the clip rectangle) and updates the
// held-button mask, and produces zero to six messages in the order move, left, middle,
// right, X1, X2, then wheel or rejected; o_last marks the final message of an event.
// The front end takes one event per cycle while its four-request queue has room; the
// back end drains the queue at one message per cycle while the output is not stalled,
// and an event with no message costs nothing at the output. Events that follow each
// other therefore overlap: the next event is classified while earlier messages are
// still going out. Configuration writes are always ready and must only be made while
// no messages are outstanding.
module mouse_cursor_event_tracker_core (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_in_valid,
    output logic                                       o_in_stall,
    input  wire signed [mcet_pkg::DELTA_BITS-1:0]      i_delta_x,
    input  wire signed [mcet_pkg::DELTA_BITS-1:0]      i_delta_y,
    input  wire        [mcet_pkg::FLAG_BITS-1:0]       i_event_flags,
    input  wire signed [mcet_pkg::DATA_BITS-1:0]       i_mouse_data,
    output logic                                       o_out_valid,
    input  wire                                        i_out_stall,
    output logic [mcet_pkg::KIND_BITS-1:0]             o_message_kind,
    output logic [mcet_pkg::MASK_BITS-1:0]             o_held_buttons,
    output logic signed [mcet_pkg::DATA_BITS-1:0]     o_detail,
    output logic [mcet_pkg::COORD_BITS-1:0]            o_pos_x,
    output logic [mcet_pkg::COORD_BITS-1:0]            o_pos_y,
    output logic                                       o_last,
    input  wire                                        i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire [mcet_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  wire [mcet_pkg::COORD_BITS-1:0]             i_cfg_data
);
    import mcet_pkg::*;

    t_cfg    r_cfg;
    logic    queue_full;
    logic    push;
    t_entry  push_entry;
    logic    q_valid;
    logic    q_pop;
    t_entry  q_head;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.clip_enable   <= 1'b0;
            r_cfg.clip_left     <= RST_CLIP_LEFT;
            r_cfg.clip_right    <= RST_CLIP_RIGHT;
            r_cfg.clip_top      <= RST_CLIP_TOP;
            r_cfg.clip_bottom   <= RST_CLIP_BOTTOM;
            r_cfg.swap_buttons  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                CFG_CLIP_ENABLE:   r_cfg.clip_enable   <= i_cfg_data[0];
                CFG_CLIP_LEFT:     r_cfg.clip_left     <= i_cfg_data;
                CFG_CLIP_RIGHT:    r_cfg.clip_right    <= i_cfg_data;
                CFG_CLIP_TOP:      r_cfg.clip_top      <= i_cfg_data;
                CFG_CLIP_BOTTOM:   r_cfg.clip_bottom   <= i_cfg_data;
                CFG_SWAP_BUTTONS:  r_cfg.swap_buttons  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // event classification
    mcet_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_delta_x     (i_delta_x),
        .i_delta_y     (i_delta_y),
        .i_event_flags (i_event_flags),
        .i_mouse_data  (i_mouse_data),
        .i_cfg         (r_cfg),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // request queue
    mcet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // message output
    mcet_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_message_kind (o_message_kind),
        .o_held_buttons (o_held_buttons),
        .o_detail       (o_detail),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
